### rtl/xpos_pkg.sv
// Shared types and constants for the XOR patch overlay store.
// Used by xor_patch_overlay_store and its testbench; depends on nothing.

package xpos_pkg;

  // Default number of image bytes held in each store.
  localparam int ImageBytesDefault = 65536;

  // Widest bit field that one bit write may insert.
  localparam logic [5:0] MaxFieldBits = 6'd57;

  // Value of the image size register after reset.
  localparam logic [16:0] ImageSizeReset = 17'h10000;

  // Operation codes carried on the operation field.
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_WRITE = 2'd1,
    OP_BITS  = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  // Sequencer states, one-hot.
  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_RUN   = 3'b100
  } state_e;

endpackage

### rtl/xpos_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing; instantiated by xor_patch_overlay_store.

module xpos_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/xor_patch_overlay_store.sv
// Top level of the XOR patch overlay store: base image RAM, overlay RAM and
// the sequencer that drives them. Depends on xpos_pkg and xpos_ram.
//
// Usage. The block holds a base image and an XOR overlay; the byte seen by a
// reader is base XOR overlay. A command transaction is taken at a rising edge
// where start is high and busy is low; operation selects a base load, a byte
// write, a bit field write or a byte read. Each command yields exactly one
// result transaction: done_o is high for one cycle with read_data_o and
// status_o valid. The receiver cannot stall, so results are never held back.
// An out-of-range command answers in the cycle after acceptance. A load
// writes its byte without a read, a byte write or read reads its byte
// first, and a bit write reads each of the n (0 to 8) bytes the field spans.
// Reads come from the registered read port of the two RAMs: each written
// byte is written back in the cycle after its read, overlapped with the
// read of the following byte. busy is high while a command runs; the
// result strobe coincides with the first cycle in which busy is low again,
// so a new command may be issued then. Reset starts a clearing pass that
// writes zero to every overlay entry, one per cycle; busy stays high
// meanwhile, while writes to the image size register are still taken.

module xor_patch_overlay_store #(
  parameter int IMAGE_BYTES = xpos_pkg::ImageBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  data_byte_i,
  input  logic [18:0] bit_offset_i,
  input  logic [5:0]  bit_count_i,
  input  logic [56:0] field_value_i,
  output logic        done_o,
  output logic [7:0]  read_data_o,
  output logic        status_o
);

  // Address width of the stores and width of the limit comparisons. The
  // limit is wide enough for both the register and the store depth.
  localparam int AddrW = $clog2(IMAGE_BYTES);
  localparam int LimW  = ($clog2(IMAGE_BYTES + 1) > 17) ? $clog2(IMAGE_BYTES + 1) : 17;

  xpos_pkg::state_e state_q, state_d;
  xpos_pkg::op_e    op_q, op_d, op_in;

  logic [16:0]      image_size_q;
  logic [AddrW-1:0] clr_q, clr_d;
  logic [AddrW-1:0] rd_idx_q, rd_idx_d;
  logic [AddrW-1:0] wr_idx_q, wr_idx_d;
  logic [3:0]       iss_q, iss_d;
  logic             rd_vld_q, rd_vld_d;
  logic [7:0]       data_q, data_d;
  logic [63:0]      mask_q, mask_d;
  logic [63:0]      bits_q, bits_d;
  logic             done_q, done_d;
  logic             status_q, status_d;
  logic [7:0]       rdata_q, rdata_d;

  // Range checks and field preparation on the incoming command.
  logic [LimW-1:0]  limit;
  logic [LimW-1:0]  size_ext;
  logic [LimW-1:0]  depth_ext;
  logic             addr_ok;
  logic             field_ok;
  logic [5:0]       cnt_sat;
  logic [19:0]      span_sum;
  logic [16:0]      end_byte;
  logic [16:0]      span_diff;
  logic [63:0]      mask_in;
  logic [63:0]      bits_in;

  // RAM ports.
  logic             base_we;
  logic [7:0]       base_wdata;
  logic [7:0]       base_rdata;
  logic             ov_we;
  logic [AddrW-1:0] ov_waddr;
  logic [7:0]       ov_wdata;
  logic [7:0]       ov_rdata;

  // Read-modify-write datapath for the byte that returns from the RAMs.
  logic [7:0]       eff_byte;
  logic [7:0]       patched;

  assign op_in     = xpos_pkg::op_e'(operation_i);
  assign size_ext  = LimW'(image_size_q);
  assign depth_ext = LimW'(IMAGE_BYTES);
  assign limit     = (size_ext < depth_ext) ? size_ext : depth_ext;
  assign addr_ok   = LimW'(address_i) < limit;

  // A field is clipped to the widest supported width, then its last byte,
  // rounded up, must not pass the limit.
  assign cnt_sat   = (bit_count_i > xpos_pkg::MaxFieldBits) ? xpos_pkg::MaxFieldBits
                                                             : bit_count_i;
  assign span_sum  = 20'(bit_offset_i) + 20'(cnt_sat) + 20'd7;
  assign end_byte  = span_sum[19:3];
  assign field_ok  = LimW'(end_byte) <= limit;
  assign span_diff = end_byte - {1'b0, bit_offset_i[18:3]};

  // The mask is built in 64 bits so that a full field at bit seven still fits.
  assign mask_in   = ((64'd1 << cnt_sat) - 64'd1) << bit_offset_i[2:0];
  assign bits_in   = ({7'd0, field_value_i} << bit_offset_i[2:0]) & mask_in;

  assign eff_byte  = base_rdata ^ ov_rdata;
  assign patched   = (eff_byte & ~mask_q[7:0]) | bits_q[7:0];

  assign busy      = (state_q != xpos_pkg::ST_IDLE);

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    clr_d      = clr_q;
    rd_idx_d   = rd_idx_q;
    wr_idx_d   = wr_idx_q;
    iss_d      = iss_q;
    rd_vld_d   = 1'b0;
    data_d     = data_q;
    mask_d     = mask_q;
    bits_d     = bits_q;
    done_d     = 1'b0;
    status_d   = status_q;
    rdata_d    = rdata_q;
    base_we    = 1'b0;
    base_wdata = data_q;
    ov_we      = 1'b0;
    ov_waddr   = wr_idx_q;
    ov_wdata   = 8'h00;

    unique case (state_q)
      xpos_pkg::ST_CLEAR: begin
        // Zero one overlay entry per cycle until the whole store is clean.
        ov_we    = 1'b1;
        ov_waddr = clr_q;
        clr_d    = clr_q + 1'b1;
        if (clr_q == AddrW'(IMAGE_BYTES - 1)) begin
          state_d = xpos_pkg::ST_IDLE;
        end
      end

      xpos_pkg::ST_IDLE: begin
        if (start) begin
          op_d   = op_in;
          data_d = data_byte_i;
          mask_d = mask_in;
          bits_d = bits_in;
          if (op_in == xpos_pkg::OP_BITS) begin
            rd_idx_d = AddrW'(bit_offset_i[18:3]);
            wr_idx_d = AddrW'(bit_offset_i[18:3]);
            iss_d    = span_diff[3:0];
          end else begin
            rd_idx_d = AddrW'(address_i);
            wr_idx_d = AddrW'(address_i);
            iss_d    = (op_in == xpos_pkg::OP_LOAD) ? 4'd0 : 4'd1;
          end
          if ((op_in == xpos_pkg::OP_BITS) ? field_ok : addr_ok) begin
            state_d = xpos_pkg::ST_RUN;
          end else begin
            // Rejected commands change nothing and answer at once.
            done_d   = 1'b1;
            status_d = 1'b1;
            rdata_d  = 8'h00;
          end
        end
      end

      xpos_pkg::ST_RUN: begin
        // Issue the read of the next byte while the previous one is written.
        if (iss_q != 4'd0) begin
          iss_d    = iss_q - 4'd1;
          rd_idx_d = rd_idx_q + 1'b1;
          rd_vld_d = 1'b1;
        end

        if (op_q == xpos_pkg::OP_LOAD) begin
          // A load sets the base byte and clears its overlay byte.
          base_we = 1'b1;
          ov_we   = 1'b1;
        end

        if (rd_vld_q) begin
          wr_idx_d = wr_idx_q + 1'b1;
          mask_d   = mask_q >> 8;
          bits_d   = bits_q >> 8;
          case (op_q)
            xpos_pkg::OP_WRITE: begin
              ov_we    = 1'b1;
              ov_wdata = base_rdata ^ data_q;
            end
            xpos_pkg::OP_BITS: begin
              ov_we    = 1'b1;
              ov_wdata = base_rdata ^ patched;
            end
            default: begin
              ov_we = 1'b0;
            end
          endcase
        end

        // With nothing left to issue, the byte in hand is the last one.
        if (iss_q == 4'd0) begin
          state_d  = xpos_pkg::ST_IDLE;
          done_d   = 1'b1;
          status_d = 1'b0;
          rdata_d  = (op_q == xpos_pkg::OP_READ) ? eff_byte : 8'h00;
        end
      end

      default: begin
        state_d = xpos_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= xpos_pkg::ST_CLEAR;
      clr_q        <= '0;
      iss_q        <= '0;
      rd_vld_q     <= 1'b0;
      done_q       <= 1'b0;
      image_size_q <= xpos_pkg::ImageSizeReset;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      iss_q    <= iss_d;
      rd_vld_q <= rd_vld_d;
      done_q   <= done_d;
      if (cfg_we_i) begin
        image_size_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    rd_idx_q <= rd_idx_d;
    wr_idx_q <= wr_idx_d;
    data_q   <= data_d;
    mask_q   <= mask_d;
    bits_q   <= bits_d;
    status_q <= status_d;
    rdata_q  <= rdata_d;
  end

  // Base image store: written only by loads, never cleared.
  xpos_ram #(
    .Width (8),
    .Depth (IMAGE_BYTES)
  ) u_base_ram (
    .clk_i   (clk_i),
    .we_i    (base_we),
    .waddr_i (wr_idx_q),
    .wdata_i (base_wdata),
    .raddr_i (rd_idx_q),
    .rdata_o (base_rdata)
  );

  // Overlay store: cleared after reset, patched by every write command.
  xpos_ram #(
    .Width (8),
    .Depth (IMAGE_BYTES)
  ) u_overlay_ram (
    .clk_i   (clk_i),
    .we_i    (ov_we),
    .waddr_i (ov_waddr),
    .wdata_i (ov_wdata),
    .raddr_i (rd_idx_q),
    .rdata_o (ov_rdata)
  );

  assign done_o      = done_q;
  assign status_o    = status_q;
  assign read_data_o = rdata_q;

endmodule

### rtl/xpos_checker.sv
// Port-level checks on the command and result transactions of the store.
// Depends on xor_patch_overlay_store, to which the bind below attaches it.

module xpos_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done_o,
  input logic       status_o,
  input logic [7:0] read_data_o
);

  // An accepted command either keeps the block busy or answers at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted command neither started work nor answered");

  // A result is shown only once the block is ready for the next command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // A result follows either running work or a command taken the cycle before.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy) || $past(start)))
    else $error("result without a command");

  // A rejected command never returns data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o) |-> (read_data_o == 8'h00))
    else $error("rejected command returned data");

endmodule

bind xor_patch_overlay_store xpos_checker u_xpos_checker (.*);

### tb/sv/xor_patch_overlay_store_test.sv
// Self-checking testbench for xor_patch_overlay_store: directed and random command
// traffic, a shadow copy of the base and overlay images, and per-field result checks.
// Depends on xpos_pkg and the xor_patch_overlay_store RTL only.
`timescale 1ns / 1ps

module xor_patch_overlay_store_test;

  // Cycles without any accepted command or result before the run is declared hung.
  localparam int StallLimit = 200000;
  // Quiet cycles after the last result, to catch stray result strobes.
  localparam int TailCycles = 24;

  // One command transaction as presented on the input ports.
  typedef struct {
    xpos_pkg::op_e op;
    logic [15:0]   address;
    logic [7:0]    data_byte;
    logic [18:0]   bit_offset;
    logic [5:0]    bit_count;
    logic [56:0]   field_value;
  } command_t;

  // The result transaction that a command is expected to produce.
  typedef struct {
    logic [7:0]    read_data;
    logic          status;
    xpos_pkg::op_e op;
    logic [15:0]   address;
  } reply_t;

  // The scoreboard keeps its own base and overlay images and the image size
  // register. Every accepted command is applied to them at once, and the
  // reply it must cause is queued. Replies come back in command order.
  class overlay_scoreboard;
    logic [7:0]  base_img    [xpos_pkg::ImageBytesDefault];
    logic [7:0]  overlay_img [xpos_pkg::ImageBytesDefault];
    bit          base_known  [xpos_pkg::ImageBytesDefault];
    logic [16:0] image_size;
    reply_t      pending_replies [$];
    int          mismatches;
    int          flagged;
    int          op_seen [4];

    function new();
      image_size = xpos_pkg::ImageSizeReset;
      foreach (overlay_img[i]) begin
        overlay_img[i] = 8'h00;
        base_img[i]    = 8'h00;
        base_known[i]  = 1'b0;
      end
      mismatches = 0;
      flagged    = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
    endfunction

    // The register saturates at the size of the stores.
    function int unsigned limit();
      return (image_size > xpos_pkg::ImageBytesDefault) ? xpos_pkg::ImageBytesDefault
                                                         : image_size;
    endfunction

    function int unsigned field_bits(command_t c);
      return (c.bit_count > xpos_pkg::MaxFieldBits) ? xpos_pkg::MaxFieldBits : c.bit_count;
    endfunction

    // One past the last byte a bit field touches.
    function int unsigned field_end(command_t c);
      return (c.bit_offset + field_bits(c) + 7) >> 3;
    endfunction

    // Returns the first base byte the command would read before it was ever
    // loaded, or -1. Such reads are outside the contract and never issued.
    function int first_unwritten(command_t c);
      int unsigned i;
      if (c.op == xpos_pkg::OP_LOAD) return -1;
      if (c.op != xpos_pkg::OP_BITS) begin
        if (c.address < limit() && !base_known[c.address]) return int'(c.address);
        return -1;
      end
      if (field_end(c) > limit()) return -1;
      for (i = c.bit_offset >> 3; i < field_end(c); i++) begin
        if (!base_known[i]) return int'(i);
      end
      return -1;
    endfunction

    // Read-modify-write of every byte the field spans. The mask is formed in
    // 64 bits, so a 57-bit field at bit 7 of a byte still fits.
    function bit insert_field(command_t c);
      int unsigned i;
      logic [63:0] mask;
      logic [63:0] bits;
      logic [7:0]  eff;
      if (field_end(c) > limit()) return 1'b1;
      mask = ((64'd1 << field_bits(c)) - 64'd1) << c.bit_offset[2:0];
      bits = ({7'd0, c.field_value} << c.bit_offset[2:0]) & mask;
      for (i = c.bit_offset >> 3; i < field_end(c); i++) begin
        eff = base_img[i] ^ overlay_img[i];
        eff = (eff & ~mask[7:0]) | bits[7:0];
        overlay_img[i] = base_img[i] ^ eff;
        mask = mask >> 8;
        bits = bits >> 8;
      end
      return 1'b0;
    endfunction

    // Applies an accepted command to the shadow images and queues its reply.
    function void note_command(command_t c);
      reply_t r;
      bit     in_range;
      in_range    = c.address < limit();
      r.read_data = 8'h00;
      r.status    = 1'b0;
      r.op        = c.op;
      r.address   = c.address;
      case (c.op)
        xpos_pkg::OP_LOAD: begin
          if (in_range) begin
            base_img[c.address]    = c.data_byte;
            overlay_img[c.address] = 8'h00;
            base_known[c.address]  = 1'b1;
          end else begin
            r.status = 1'b1;
          end
        end
        xpos_pkg::OP_WRITE: begin
          if (in_range) overlay_img[c.address] = base_img[c.address] ^ c.data_byte;
          else r.status = 1'b1;
        end
        xpos_pkg::OP_BITS: begin
          r.status = insert_field(c);
        end
        default: begin
          if (in_range) r.read_data = base_img[c.address] ^ overlay_img[c.address];
          else r.status = 1'b1;
        end
      endcase
      op_seen[c.op]++;
      if (r.status) flagged++;
      pending_replies.push_back(r);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Compares one result transaction with the oldest queued reply.
    task check_result(logic [7:0] rd, logic st);
      reply_t r;
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("result rd=%02h st=%0b with no command outstanding",
                                  rd, st));
      end else begin
        r = pending_replies.pop_front();
        if (rd !== r.read_data)
          report_mismatch($sformatf("%s @%04h read_data %02h, want %02h",
                                    r.op.name(), r.address, rd, r.read_data));
        if (st !== r.status)
          report_mismatch($sformatf("%s @%04h status %0b, want %0b",
                                    r.op.name(), r.address, st, r.status));
      end
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [16:0] cfg_wdata_i;
  logic        start;
  logic        busy;
  logic [1:0]  operation_i;
  logic [15:0] address_i;
  logic [7:0]  data_byte_i;
  logic [18:0] bit_offset_i;
  logic [5:0]  bit_count_i;
  logic [56:0] field_value_i;
  logic        done_o;
  logic [7:0]  read_data_o;
  logic        status_o;

  overlay_scoreboard shadow;
  logic [16:0]       size_plan [8];
  int                gap_before = 0;
  int                quiet_run = 0;
  int                stall_cycles = 0;
  int                settings_used = 0;

  xor_patch_overlay_store dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .start        (start),
    .busy         (busy),
    .operation_i  (operation_i),
    .address_i    (address_i),
    .data_byte_i  (data_byte_i),
    .bit_offset_i (bit_offset_i),
    .bit_count_i  (bit_count_i),
    .field_value_i(field_value_i),
    .done_o       (done_o),
    .read_data_o  (read_data_o),
    .status_o     (status_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Results cannot be stalled, so every strobe is a transaction. Values are
  // read right after the edge, which still shows what the edge sampled.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) shadow.check_result(read_data_o, status_o);
  end

  // Watchdog: any accepted command or result restarts the count.
  always @(posedge clk_i) begin
    if (rst_ni && ((start && !busy) || done_o)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("watchdog: no transaction for %0d cycles", StallLimit);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Idle cycles before the next command. Mostly uniform over 0..17 so gaps
  // land on every cycle of a multi-byte bit write, with back-to-back bursts.
  function int draw_gap();
    if (quiet_run > 0) begin
      quiet_run--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      quiet_run = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  // Presents one command and returns at the edge that accepts it. start is
  // kept high only when the next command follows with no gap, so that it is
  // never lowered and raised within one time step. hold_off forces it low
  // because the caller is about to wait for the block to drain.
  task automatic send_command(command_t c, bit hold_off);
    repeat (gap_before) @(posedge clk_i);
    start         <= 1'b1;
    operation_i   <= c.op;
    address_i     <= c.address;
    data_byte_i   <= c.data_byte;
    bit_offset_i  <= c.bit_offset;
    bit_count_i   <= c.bit_count;
    field_value_i <= c.field_value;
    do @(posedge clk_i); while (busy);
    shadow.note_command(c);
    gap_before = draw_gap();
    if (hold_off || gap_before != 0) start <= 1'b0;
  endtask

  task automatic wait_drained();
    while (shadow.pending_replies.size() != 0) @(posedge clk_i);
  endtask

  // The register is only written while no command is in flight.
  task automatic write_image_size(logic [16:0] value);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shadow.image_size = value;
    settings_used++;
  endtask

  // Byte commands; the fields they do not use carry noise.
  function command_t byte_command(xpos_pkg::op_e op, logic [15:0] address,
                                  logic [7:0] data);
    command_t c;
    c.op          = op;
    c.address     = address;
    c.data_byte   = data;
    c.bit_offset  = 19'($urandom);
    c.bit_count   = 6'($urandom);
    c.field_value = 57'({$urandom, $urandom});
    return c;
  endfunction

  function command_t field_command(logic [18:0] offset, logic [5:0] count,
                                   logic [56:0] value);
    command_t c;
    c.op          = xpos_pkg::OP_BITS;
    c.address     = 16'($urandom);
    c.data_byte   = 8'($urandom);
    c.bit_offset  = offset;
    c.bit_count   = count;
    c.field_value = value;
    return c;
  endfunction

  // Addresses cluster in a low window and around the current limit, where
  // bytes get loaded, patched and read back, and where the bound check bites.
  function logic [15:0] pick_address();
    int a;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: a = $urandom_range(0, 63);
      4, 5, 6, 7: a = int'(shadow.limit()) - 24 + int'($urandom_range(0, 40));
      default:    a = $urandom_range(0, 65535);
    endcase
    if (a < 0) a = $urandom_range(0, 15);
    if (a > 65535) a = 65535;
    return a[15:0];
  endfunction

  function logic [5:0] pick_count();
    case ($urandom_range(0, 9))
      0:       return 6'd0;
      1:       return 6'($urandom_range(58, 63));
      2:       return xpos_pkg::MaxFieldBits;
      default: return 6'($urandom_range(1, 57));
    endcase
  endfunction

  // A random command. One that would read a base byte never loaded turns
  // into a load of that byte, so the image fills up where traffic goes.
  function command_t random_command();
    command_t c;
    int       hole;
    c.op          = xpos_pkg::op_e'($urandom_range(0, 3));
    c.address     = pick_address();
    c.data_byte   = 8'($urandom);
    c.bit_offset  = {pick_address(), 3'($urandom_range(0, 7))};
    c.bit_count   = pick_count();
    c.field_value = 57'({$urandom, $urandom});
    hole = shadow.first_unwritten(c);
    if (hole >= 0) begin
      c.op      = xpos_pkg::OP_LOAD;
      c.address = hole[15:0];
    end
    return c;
  endfunction

  // Directed opening under the reset size: both ends of the address range,
  // a full-width field at bit 7, a saturated count, zero-width fields with
  // and without a partial byte, fields ending exactly at and just past the
  // last byte, and a reload that wipes an overlay byte.
  task automatic run_directed();
    int i;
    send_command(byte_command(xpos_pkg::OP_LOAD, 16'd0, 8'h00), 1'b0);
    send_command(byte_command(xpos_pkg::OP_LOAD, 16'd1, 8'hFF), 1'b0);
    for (i = 2; i <= 8; i++)
      send_command(byte_command(xpos_pkg::OP_LOAD, 16'(i), 8'($urandom)), 1'b0);
    send_command(byte_command(xpos_pkg::OP_LOAD, 16'hFFFF, 8'h5A), 1'b0);
    send_command(byte_command(xpos_pkg::OP_READ, 16'd0, 8'hFF), 1'b0);
    send_command(byte_command(xpos_pkg::OP_READ, 16'hFFFF, 8'h00), 1'b0);
    send_command(byte_command(xpos_pkg::OP_WRITE, 16'd1, 8'h3C), 1'b0);
    send_command(byte_command(xpos_pkg::OP_READ, 16'd1, 8'h00), 1'b0);
    send_command(field_command(19'd7, xpos_pkg::MaxFieldBits, {57{1'b1}}), 1'b0);
    send_command(byte_command(xpos_pkg::OP_READ, 16'd4, 8'h00), 1'b0);
    send_command(field_command(19'd3, 6'd63, 57'({$urandom, $urandom})), 1'b0);
    send_command(field_command(19'd12, 6'd0, {57{1'b1}}), 1'b0);
    send_command(field_command(19'd16, 6'd0, {57{1'b1}}), 1'b0);
    send_command(field_command(19'h7FFFF, 6'd1, 57'd1), 1'b0);
    send_command(byte_command(xpos_pkg::OP_READ, 16'hFFFF, 8'h00), 1'b0);
    send_command(field_command(19'h7FFFF, 6'd2, 57'd3), 1'b0);
    send_command(field_command(19'h7FFF8, xpos_pkg::MaxFieldBits, 57'd0), 1'b0);
    send_command(byte_command(xpos_pkg::OP_LOAD, 16'd1, 8'h11), 1'b0);
    send_command(byte_command(xpos_pkg::OP_READ, 16'd1, 8'h00), 1'b1);
    wait_drained();
  endtask

  initial begin
    int  p;
    int  n;
    int  items;
    bit  pause;
    shadow = new();
    // Size settings per phase: empty, one byte, a small image, the saturating
    // maximum, a mid size, one byte short of full, a random size, the full store.
    size_plan     = '{17'd0, 17'd1, 17'd96, 17'h1FFFF, 17'd4096, 17'd65535,
                      17'd40000, xpos_pkg::ImageSizeReset};
    size_plan[6]  = 17'($urandom_range(16, 65536));
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    start         <= 1'b0;
    operation_i   <= xpos_pkg::OP_READ;
    address_i     <= '0;
    data_byte_i   <= '0;
    bit_offset_i  <= '0;
    bit_count_i   <= '0;
    field_value_i <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The first command waits out the overlay clearing pass behind busy.
    run_directed();

    // Random phases. Each ends with the sender holding off until every
    // reply is in, and some pause in the middle as well.
    for (p = 0; p < 8; p++) begin
      write_image_size(size_plan[p]);
      items = (size_plan[p] == 0) ? 40 : 260;
      for (n = 0; n < items; n++) begin
        pause = ($urandom_range(0, 79) == 0) || (n == items - 1);
        send_command(random_command(), pause);
        if (pause) wait_drained();
      end
    end

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    $display("Covered %0d loads, %0d byte writes, %0d bit-field writes and %0d reads,",
             shadow.op_seen[xpos_pkg::OP_LOAD], shadow.op_seen[xpos_pkg::OP_WRITE],
             shadow.op_seen[xpos_pkg::OP_BITS], shadow.op_seen[xpos_pkg::OP_READ]);
    $display("%0d of them flagged out of range, over %0d image size settings.",
             shadow.flagged, settings_used + 1);
    if (shadow.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
